/* src/assert_macros.svh */
// assertion helpers shared by the top and den modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define BSK_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen outside reset
`define BSK_NEVER(lbl, clk, rst_n, cond, msg) \
  `BSK_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

/* src/bsk_pkg.sv */
// ----------------------------------------------------------------------------
// bsk_pkg
// Widths, payload types and status codes of the point kernel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bsk_pkg;

  localparam int CoordW   = 32;   // input field width, Q16.16
  localparam int DiffW    = 33;   // difference vector, signed
  localparam int DMagW    = 33;   // |d| per axis
  localparam int LMagW    = 32;   // |l| per axis
  localparam int ProdW    = 64;   // |l| * |d|
  localparam int MagW     = 65;   // cross product magnitude
  localparam int QW       = 66;   // sum of squares
  localparam int XW       = 98;   // q << 32
  localparam int RootW    = 49;   // floor sqrt
  localparam int DenW     = 115;  // q * r
  localparam int RemW     = 116;  // division residual
  localparam int QuoW     = 48;   // quotient bits kept
  localparam int OutW     = 48;   // Q24.24 result
  localparam int NumShift = 56;   // numerator scale

  localparam int QLoW = 33;       // den product split of q
  localparam int RLoW = 25;       // den product split of r

  localparam logic [OutW-1:0] PosLim = {1'b0, {(OutW-1){1'b1}}};
  localparam logic [OutW-1:0] NegLim = {1'b1, {(OutW-1){1'b0}}};

  localparam int DefCoordWidth = 32;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_ZERO = 2'd2
  } status_e;

  typedef struct packed {
    logic [QW-1:0]              q;
    logic [2:0][MagW-1:0]       m;
    logic [2:0]                 neg;
    logic                       zero;
  } kern_t;

endpackage

/* src/biot_savart_point_kernel_top.sv */
// ----------------------------------------------------------------------------
// biot_savart_point_kernel_top
// Biot-Savart point kernel (L x d)/|d|^3, Q24.24, one pair per unstalled cycle.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid_i with nine Q16.16 coordinates (evaluation
//   point, source point, current element); a transfer happens when
//   in_valid_i is high and in_stall_o is low.
//   Output channel: out_valid_o with field_x/y/z_o (Q24.24, saturated) and
//   status_o (ok, saturated, zero distance); a transfer happens when
//   out_valid_o is high and out_stall_i is low.
//   From input transfer to out_valid_o a pair passes 3 front stages,
//   49 square root stages (one root bit each), 2 stages for the
//   distance cube product, 49 divider stages (an overflow check, then one
//   quotient bit each) and the output register.
//   Throughput: one pair per unstalled cycle; every stage is a register.
//   When the receiver stalls with a result waiting, the whole pipeline
//   freezes and in_stall_o follows out_stall_i; nothing is lost or repeated.
//   Reset empties the pipeline; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module biot_savart_point_kernel_top
  import bsk_pkg::*;
#(
  parameter int COORD_WIDTH = DefCoordWidth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [CoordW-1:0] eval_x_i,
  input  logic [CoordW-1:0] eval_y_i,
  input  logic [CoordW-1:0] eval_z_i,
  input  logic [CoordW-1:0] src_x_i,
  input  logic [CoordW-1:0] src_y_i,
  input  logic [CoordW-1:0] src_z_i,
  input  logic [CoordW-1:0] elem_x_i,
  input  logic [CoordW-1:0] elem_y_i,
  input  logic [CoordW-1:0] elem_z_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [OutW-1:0]   field_x_o,
  output logic [OutW-1:0]   field_y_o,
  output logic [OutW-1:0]   field_z_o,
  output logic [1:0]        status_o
);

  localparam int KernW = $bits(kern_t);

  logic en;
  logic out_vld_q;

  // the pipeline moves unless a finished result is held up
  assign en         = !(out_vld_q && out_stall_i);
  assign in_stall_o = !en;

  logic  fr_vld;
  kern_t fr_kern;

  bsk_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .vld_i    (in_valid_i),
    .eval_x_i (eval_x_i),
    .eval_y_i (eval_y_i),
    .eval_z_i (eval_z_i),
    .src_x_i  (src_x_i),
    .src_y_i  (src_y_i),
    .src_z_i  (src_z_i),
    .elem_x_i (elem_x_i),
    .elem_y_i (elem_y_i),
    .elem_z_i (elem_z_i),
    .vld_o    (fr_vld),
    .kern_o   (fr_kern)
  );

  logic             sq_vld;
  logic [RootW-1:0] sq_root;
  kern_t            sq_kern;

  bsk_sqrt #(
    .SideW(KernW)
  ) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (fr_vld),
    .x_i    ({fr_kern.q, {(XW-QW){1'b0}}}),
    .side_i (fr_kern),
    .vld_o  (sq_vld),
    .root_o (sq_root),
    .side_o (sq_kern)
  );

  logic            dn_vld;
  logic [DenW-1:0] dn_den;
  kern_t           dn_kern;

  bsk_den #(
    .SideW(KernW)
  ) u_den (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (sq_vld),
    .q_i    (sq_kern.q),
    .root_i (sq_root),
    .side_i (sq_kern),
    .vld_o  (dn_vld),
    .den_o  (dn_den),
    .side_o (dn_kern)
  );

  logic            dv_vld;
  logic [QuoW-1:0] dv_quo [3];
  logic [2:0]      dv_ovf;
  logic [2:0]      dv_neg;
  logic            dv_zero;

  bsk_div #(
    .SideW(2)
  ) u_div_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (dn_vld),
    .m_i    (dn_kern.m[0]),
    .den_i  (dn_den),
    .side_i ({dn_kern.zero, dn_kern.neg[0]}),
    .vld_o  (dv_vld),
    .quo_o  (dv_quo[0]),
    .ovf_o  (dv_ovf[0]),
    .side_o ({dv_zero, dv_neg[0]})
  );

  bsk_div #(
    .SideW(1)
  ) u_div_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (dn_vld),
    .m_i    (dn_kern.m[1]),
    .den_i  (dn_den),
    .side_i (dn_kern.neg[1]),
    .vld_o  (),
    .quo_o  (dv_quo[1]),
    .ovf_o  (dv_ovf[1]),
    .side_o (dv_neg[1])
  );

  bsk_div #(
    .SideW(1)
  ) u_div_z (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (dn_vld),
    .m_i    (dn_kern.m[2]),
    .den_i  (dn_den),
    .side_i (dn_kern.neg[2]),
    .vld_o  (),
    .quo_o  (dv_quo[2]),
    .ovf_o  (dv_ovf[2]),
    .side_o (dv_neg[2])
  );

  // saturation, sign and status
  logic [OutW-1:0] fld_d [3], fld_q [3];
  status_e         status_d, status_q;

  always_comb begin
    logic [OutW-1:0] lim, val;
    logic [2:0]      sat;
    for (int c = 0; c < 3; c++) begin
      lim    = dv_neg[c] ? NegLim : PosLim;
      sat[c] = dv_ovf[c] || (OutW'(dv_quo[c]) > lim);
      val    = sat[c] ? lim : OutW'(dv_quo[c]);
      fld_d[c] = dv_zero ? '0 : (dv_neg[c] ? OutW'(-val) : val);
    end
    if (dv_zero) status_d = ST_ZERO;
    else if (sat != '0) status_d = ST_SAT;
    else status_d = ST_OK;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fld_q    <= fld_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (en) out_vld_q <= dv_vld;
  end

  assign out_valid_o = out_vld_q;
  assign field_x_o   = fld_q[0];
  assign field_y_o   = fld_q[1];
  assign field_z_o   = fld_q[2];
  assign status_o    = status_q;

  `BSK_ASSERT(a_zero_fields, clk_i, rst_ni, out_valid_o && status_o == ST_ZERO |-> field_x_o == '0 && field_y_o == '0 && field_z_o == '0, "zero distance with nonzero field")
  `BSK_ASSERT(a_sat_limit, clk_i, rst_ni, out_valid_o && status_o == ST_SAT |-> field_x_o == PosLim || field_x_o == NegLim || field_y_o == PosLim || field_y_o == NegLim || field_z_o == PosLim || field_z_o == NegLim, "saturation flagged with no component at a limit")
  `BSK_ASSERT(a_stall_only_full, clk_i, rst_ni, in_stall_o |-> out_vld_q && out_stall_i, "input stalled while output free")

endmodule

/* src/bsk_front.sv */
// ----------------------------------------------------------------------------
// bsk_front
// Difference vector, squares and cross product magnitudes in three stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsk_front
  import bsk_pkg::*;
#(
  parameter int COORD_WIDTH = DefCoordWidth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  logic [CoordW-1:0] eval_x_i,
  input  logic [CoordW-1:0] eval_y_i,
  input  logic [CoordW-1:0] eval_z_i,
  input  logic [CoordW-1:0] src_x_i,
  input  logic [CoordW-1:0] src_y_i,
  input  logic [CoordW-1:0] src_z_i,
  input  logic [CoordW-1:0] elem_x_i,
  input  logic [CoordW-1:0] elem_y_i,
  input  logic [CoordW-1:0] elem_z_i,
  output logic              vld_o,
  output kern_t             kern_o
);

  localparam int EffW = (COORD_WIDTH > CoordW) ? CoordW : COORD_WIDTH;

  function automatic logic [CoordW-1:0] sext(input logic [CoordW-1:0] v);
    logic [CoordW-1:0] r;
    r = v;
    for (int i = EffW; i < CoordW; i++) r[i] = v[EffW-1];
    return r;
  endfunction

  logic [CoordW-1:0] e_w [3];
  logic [CoordW-1:0] s_w [3];
  logic [CoordW-1:0] l_w [3];

  assign e_w[0] = eval_x_i;
  assign e_w[1] = eval_y_i;
  assign e_w[2] = eval_z_i;
  assign s_w[0] = src_x_i;
  assign s_w[1] = src_y_i;
  assign s_w[2] = src_z_i;
  assign l_w[0] = elem_x_i;
  assign l_w[1] = elem_y_i;
  assign l_w[2] = elem_z_i;

  // stage 1: magnitudes and signs
  logic [DMagW-1:0] dmag_d [3], dmag_q [3];
  logic [LMagW-1:0] lmag_d [3], lmag_q [3];
  logic [2:0]       dneg_d, dneg_q, lneg_d, lneg_q;
  logic             vld1_q, vld2_q, vld3_q;

  always_comb begin
    logic signed [DiffW-1:0] d;
    logic        [CoordW-1:0] l;
    for (int i = 0; i < 3; i++) begin
      d = DiffW'(signed'(sext(e_w[i]))) - DiffW'(signed'(sext(s_w[i])));
      l = sext(l_w[i]);
      dneg_d[i] = d[DiffW-1];
      dmag_d[i] = d[DiffW-1] ? DMagW'(-d) : DMagW'(d);
      lneg_d[i] = l[CoordW-1];
      lmag_d[i] = l[CoordW-1] ? LMagW'(-l) : LMagW'(l);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dmag_q <= dmag_d;
      lmag_q <= lmag_d;
      dneg_q <= dneg_d;
      lneg_q <= lneg_d;
    end
  end

  // stage 2: squares and the six cross terms
  logic [QW-1:0]    sq_q [3];
  logic [ProdW-1:0] p1_q [3], p2_q [3];
  logic [2:0]       s1_q, s2_q;

  for (genvar c = 0; c < 3; c++) begin : g_prod
    localparam int A = (c + 1) % 3;
    localparam int B = (c + 2) % 3;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sq_q[c] <= QW'(dmag_q[c] * dmag_q[c]);
        p1_q[c] <= ProdW'(lmag_q[A] * dmag_q[B]);
        p2_q[c] <= ProdW'(lmag_q[B] * dmag_q[A]);
        s1_q[c] <= lneg_q[A] ^ dneg_q[B];
        s2_q[c] <= !(lneg_q[B] ^ dneg_q[A]);
      end
    end
  end

  // stage 3: sum of squares and signed combine
  kern_t kern_d, kern_q;

  always_comb begin
    kern_d.q = sq_q[0] + sq_q[1] + sq_q[2];
    kern_d.zero = (kern_d.q == '0);
    for (int c = 0; c < 3; c++) begin
      if (s1_q[c] == s2_q[c]) begin
        kern_d.m[c]   = MagW'(p1_q[c]) + MagW'(p2_q[c]);
        kern_d.neg[c] = s1_q[c];
      end else if (p1_q[c] >= p2_q[c]) begin
        kern_d.m[c]   = MagW'(p1_q[c] - p2_q[c]);
        kern_d.neg[c] = s1_q[c];
      end else begin
        kern_d.m[c]   = MagW'(p2_q[c] - p1_q[c]);
        kern_d.neg[c] = s2_q[c];
      end
      if (kern_d.m[c] == '0) kern_d.neg[c] = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) kern_q <= kern_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
    end
  end

  assign vld_o  = vld3_q;
  assign kern_o = kern_q;

endmodule

/* src/bsk_sqrt.sv */
// ----------------------------------------------------------------------------
// bsk_sqrt
// Pipelined digit-by-digit integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsk_sqrt
  import bsk_pkg::*;
#(
  parameter int SideW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             vld_i,
  input  logic [XW-1:0]    x_i,
  input  logic [SideW-1:0] side_i,
  output logic             vld_o,
  output logic [RootW-1:0] root_o,
  output logic [SideW-1:0] side_o
);

  logic [RootW-1:0] root_q [RootW];
  logic [XW-1:0]    res_q  [RootW-1];
  logic [SideW-1:0] side_q [RootW];
  logic             vld_q  [RootW];

  for (genvar k = 0; k < RootW; k++) begin : g_stage
    localparam int B = RootW - 1 - k;
    logic [RootW-1:0] root_in;
    logic [XW-1:0]    res_in;
    logic [SideW-1:0] side_in;
    logic             vld_in;
    logic [XW:0]      inc;
    logic             take;

    if (k == 0) begin : g_first
      assign root_in = '0;
      assign res_in  = x_i;
      assign side_in = side_i;
      assign vld_in  = vld_i;
    end else begin : g_next
      assign root_in = root_q[k-1];
      assign res_in  = res_q[k-1];
      assign side_in = side_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    // (r + 2^b)^2 - r^2
    always_comb begin
      inc  = ((XW+1)'(root_in) << (B + 1)) + ((XW+1)'(1) << (2 * B));
      take = ((XW+1)'(res_in) >= inc);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vld_q[k] <= 1'b0;
      else if (en_i) vld_q[k] <= vld_in;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[k] <= take ? (root_in | (RootW'(1) << B)) : root_in;
        side_q[k] <= side_in;
      end
    end

    if (k < RootW - 1) begin : g_res
      always_ff @(posedge clk_i) begin
        if (en_i) res_q[k] <= take ? XW'((XW+1)'(res_in) - inc) : res_in;
      end
    end
  end

  assign vld_o  = vld_q[RootW-1];
  assign root_o = root_q[RootW-1];
  assign side_o = side_q[RootW-1];

endmodule

/* src/bsk_den.sv */
// ----------------------------------------------------------------------------
// bsk_den
// Cube of the distance, q * r, from four partial products over two stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module bsk_den
  import bsk_pkg::*;
#(
  parameter int SideW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             vld_i,
  input  logic [QW-1:0]    q_i,
  input  logic [RootW-1:0] root_i,
  input  logic [SideW-1:0] side_i,
  output logic             vld_o,
  output logic [DenW-1:0]  den_o,
  output logic [SideW-1:0] side_o
);

  localparam int QHiW = QW - QLoW;
  localparam int RHiW = RootW - RLoW;

  logic [QLoW+RLoW-1:0] p00_q;
  logic [QLoW+RHiW-1:0] p01_q;
  logic [QHiW+RLoW-1:0] p10_q;
  logic [QHiW+RHiW-1:0] p11_q;
  logic [SideW-1:0]     side1_q, side2_q;
  logic [DenW-1:0]      den_q;
  logic                 vld1_q, vld2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p00_q   <= (QLoW+RLoW)'(q_i[QLoW-1:0]  * root_i[RLoW-1:0]);
      p01_q   <= (QLoW+RHiW)'(q_i[QLoW-1:0]  * root_i[RootW-1:RLoW]);
      p10_q   <= (QHiW+RLoW)'(q_i[QW-1:QLoW] * root_i[RLoW-1:0]);
      p11_q   <= (QHiW+RHiW)'(q_i[QW-1:QLoW] * root_i[RootW-1:RLoW]);
      side1_q <= side_i;
      den_q   <= DenW'(p00_q)
               + (DenW'(p01_q) << RLoW)
               + (DenW'(p10_q) << QLoW)
               + (DenW'(p11_q) << (QLoW + RLoW));
      side2_q <= side1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
    end
  end

  assign vld_o  = vld2_q;
  assign den_o  = den_q;
  assign side_o = side2_q;

  `BSK_ASSERT(a_vld_travel, clk_i, rst_ni, $past(en_i, 1) && $past(en_i, 2) |-> vld_o == $past(vld_i, 2), "valid bit lost in den stages")
  `BSK_ASSERT(a_vld_hold, clk_i, rst_ni, !$past(en_i) |-> $stable(vld2_q) && $stable(den_q), "den stage moved while frozen")

endmodule

/* src/bsk_div.sv */
// ----------------------------------------------------------------------------
// bsk_div
// Pipelined restoring divider: (m << 56) / den, one quotient bit per stage,
// with overflow detected up front.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsk_div
  import bsk_pkg::*;
#(
  parameter int SideW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             vld_i,
  input  logic [MagW-1:0]  m_i,
  input  logic [DenW-1:0]  den_i,
  input  logic [SideW-1:0] side_i,
  output logic             vld_o,
  output logic [QuoW-1:0]  quo_o,
  output logic             ovf_o,
  output logic [SideW-1:0] side_o
);

  // stage 0: high part of the numerator and overflow check
  logic [RemW-1:0]  rem0_q;
  logic [DenW-1:0]  den0_q;
  logic             ovf0_q, vld0_q;
  logic [SideW-1:0] side0_q;
  logic [RemW-1:0]  rem0_d;

  assign rem0_d = RemW'(m_i) << (NumShift - QuoW);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem0_q  <= rem0_d;
      den0_q  <= den_i;
      ovf0_q  <= (rem0_d >= RemW'(den_i));
      side0_q <= side_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld0_q <= 1'b0;
    else if (en_i) vld0_q <= vld_i;
  end

  logic [RemW-1:0]  rem_q  [QuoW-1];
  logic [DenW-1:0]  den_q  [QuoW-1];
  logic [QuoW-1:0]  quo_q  [QuoW];
  logic             ovf_q  [QuoW];
  logic [SideW-1:0] side_q [QuoW];
  logic             vld_q  [QuoW];

  for (genvar k = 0; k < QuoW; k++) begin : g_stage
    logic [RemW-1:0]  rem_in, sh;
    logic [DenW-1:0]  den_in;
    logic [QuoW-1:0]  quo_in;
    logic             ovf_in, vld_in, take;
    logic [SideW-1:0] side_in;

    if (k == 0) begin : g_first
      assign rem_in  = rem0_q;
      assign den_in  = den0_q;
      assign quo_in  = '0;
      assign ovf_in  = ovf0_q;
      assign side_in = side0_q;
      assign vld_in  = vld0_q;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign den_in  = den_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign ovf_in  = ovf_q[k-1];
      assign side_in = side_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    assign sh   = rem_in << 1;
    assign take = (sh >= RemW'(den_in));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vld_q[k] <= 1'b0;
      else if (en_i) vld_q[k] <= vld_in;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[k]  <= {quo_in[QuoW-2:0], take};
        ovf_q[k]  <= ovf_in;
        side_q[k] <= side_in;
      end
    end

    if (k < QuoW - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k] <= take ? (sh - RemW'(den_in)) : sh;
          den_q[k] <= den_in;
        end
      end
    end
  end

  assign vld_o  = vld_q[QuoW-1];
  assign quo_o  = quo_q[QuoW-1];
  assign ovf_o  = ovf_q[QuoW-1];
  assign side_o = side_q[QuoW-1];

endmodule

/* dv/biot_savart_point_kernel_top_tb.sv */
// ----------------------------------------------------------------------------
// biot_savart_point_kernel_top_tb
// Streams point pairs through the kernel with random idling on both channels
// and checks every field component and status against a bit-exact predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module biot_savart_point_kernel_top_tb;
  import bsk_pkg::*;

  localparam int NumRandom = 450;
  localparam int IdleLimit = 5000;
  localparam int DrainWait = 150;

  typedef logic [CoordW-1:0] coord_t;

  typedef struct {
    logic [OutW-1:0] fx;
    logic [OutW-1:0] fy;
    logic [OutW-1:0] fz;
    status_e         st;
  } field_t;

  class field_scoreboard;
    field_t pending_q[$];
    int     mismatches;
    int     n_checked;
    int     n_sat;
    int     n_zero;

    // one cross component, scaled to Q24.24 with saturation
    function logic [OutW-1:0] cross_term(logic signed [33:0] a1, logic signed [33:0] b1,
                                         logic signed [33:0] a2, logic signed [33:0] b2,
                                         logic [114:0] den, inout bit sat);
      logic signed [67:0] p;
      logic [67:0]        m;
      logic [123:0]       quo;
      logic [47:0]        lim;
      logic               neg;
      p   = a1 * b1 - a2 * b2;
      neg = p < 0;
      m   = neg ? -p : p;
      quo = {m, 56'b0} / den;
      lim = neg ? NegLim : PosLim;
      if (quo > lim) begin
        sat = 1;
        quo = lim;
      end
      return neg ? -quo[47:0] : quo[47:0];
    endfunction

    function field_t biot_field(coord_t v[9]);
      logic signed [33:0] d[3];
      logic signed [33:0] l[3];
      logic [65:0]        q;
      logic [97:0]        x;
      logic [48:0]        r;
      logic [48:0]        t;
      logic [114:0]       den;
      bit                 sat;
      field_t             f;
      for (int i = 0; i < 3; i++) begin
        d[i] = 34'($signed(v[i])) - 34'($signed(v[3+i]));
        l[i] = 34'($signed(v[6+i]));
      end
      q = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
      if (q == 0) begin
        f.fx = '0; f.fy = '0; f.fz = '0; f.st = ST_ZERO;
        return f;
      end
      x = {q, 32'b0};
      r = '0;
      for (int b = 48; b >= 0; b--) begin
        t = r | (49'd1 << b);
        if (98'(t) * 98'(t) <= x) r = t;
      end
      den  = 115'(q) * 115'(r);
      sat  = 0;
      f.fx = cross_term(l[1], d[2], l[2], d[1], den, sat);
      f.fy = cross_term(l[2], d[0], l[0], d[2], den, sat);
      f.fz = cross_term(l[0], d[1], l[1], d[0], den, sat);
      f.st = sat ? ST_SAT : ST_OK;
      return f;
    endfunction

    function void note_input(coord_t v[9]);
      pending_q.push_back(biot_field(v));
    endfunction

    function void check_result(logic [OutW-1:0] fx, logic [OutW-1:0] fy,
                               logic [OutW-1:0] fz, logic [1:0] st);
      field_t e;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer at %0t", $realtime);
        return;
      end
      e = pending_q.pop_front();
      n_checked++;
      if (st == ST_SAT) n_sat++;
      if (st == ST_ZERO) n_zero++;
      if (fx !== e.fx || fy !== e.fy || fz !== e.fz || st !== e.st) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch %0d: exp %h %h %h st %0d, got %h %h %h st %0d",
                   n_checked, e.fx, e.fy, e.fz, e.st, fx, fy, fz, st);
      end
    endfunction
  endclass

  logic            clk_i;
  logic            rst_ni;
  logic            in_valid_i;
  logic            in_stall_o;
  coord_t          eval_x_i, eval_y_i, eval_z_i;
  coord_t          src_x_i, src_y_i, src_z_i;
  coord_t          elem_x_i, elem_y_i, elem_z_i;
  logic            out_valid_o;
  logic            out_stall_i;
  logic [OutW-1:0] field_x_o, field_y_o, field_z_o;
  logic [1:0]      status_o;

  field_scoreboard sb;
  int              snd_idle;
  int              rcv_idle;
  int              n_sent;
  int              quiet_cycles;

  biot_savart_point_kernel_top dut (.*);

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < rcv_idle);
  end

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i)
      sb.check_result(field_x_o, field_y_o, field_z_o, status_o);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IdleLimit) begin
        $display("watchdog: no transfer for %0d cycles", IdleLimit);
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic send_pair(coord_t v[9]);
    while ($urandom_range(99) < snd_idle) begin
      in_valid_i = 0;
      @(negedge clk_i);
    end
    {eval_x_i, eval_y_i, eval_z_i} = {v[0], v[1], v[2]};
    {src_x_i, src_y_i, src_z_i}    = {v[3], v[4], v[5]};
    {elem_x_i, elem_y_i, elem_z_i} = {v[6], v[7], v[8]};
    in_valid_i = 1;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(v);
    n_sent++;
    @(negedge clk_i);
  endtask

  // signed value with a random magnitude class
  function automatic coord_t scaled_rand();
    coord_t c;
    c = $urandom() >> $urandom_range(31, 1);
    return $urandom_range(1) ? -c : c;
  endfunction

  task automatic send_random();
    coord_t v[9];
    int     kind;
    kind = $urandom_range(99);
    for (int i = 0; i < 9; i++) v[i] = $urandom();
    if (kind < 5) begin
      // coincident points
      for (int i = 0; i < 3; i++) v[i] = v[3+i];
    end else if (kind < 80) begin
      for (int i = 0; i < 3; i++) begin
        v[i]   = v[3+i] + scaled_rand();
        v[6+i] = scaled_rand();
      end
    end
    send_pair(v);
  endtask

  task automatic send_directed();
    coord_t mx, mn, one;
    coord_t v[9];
    mx  = 32'h7fffffff;
    mn  = 32'h80000000;
    one = 32'h00010000;
    v = '{default: '0};                                             send_pair(v);
    v = '{mx, mx, mx, mx, mx, mx, mx, mn, mx};                      send_pair(v);
    v = '{mx, mx, mx, mn, mn, mn, mx, mn, mn};                      send_pair(v);
    v = '{mn, mn, mn, mx, mx, mx, mn, mn, mn};                      send_pair(v);
    v = '{mx, mn, mx, mn, mx, mn, mn, mx, mn};                      send_pair(v);
    v = '{one, 0, 0, 0, 0, 0, 0, one, 0};                           send_pair(v);
    v = '{0, one, 0, 0, 0, 0, 0, 0, one};                           send_pair(v);
    v = '{0, 0, one, 0, 0, 0, one, 0, 0};                           send_pair(v);
    // smallest separation with the largest element saturates
    v = '{1, 0, 0, 0, 0, 0, 0, mx, mn};                             send_pair(v);
    v = '{0, 1, 0, 0, 0, 0, mn, 0, mx};                             send_pair(v);
    v = '{0, 0, 32'hffffffff, 0, 0, 0, mx, mx, 0};                  send_pair(v);
    v = '{one, one, one, 0, 0, 0, mx, mn, 1};                       send_pair(v);
    v = '{1, 1, 1, 0, 0, 0, 1, 1, 1};                               send_pair(v);
    v = '{mn, mx, 0, mn, mx, 0, mx, mx, mx};                        send_pair(v);
    v = '{32'h00000100, 0, 0, 0, 32'h00000100, 0, 0, 0, mx};        send_pair(v);
    v = '{32'hffffffff, 32'hffffffff, 32'hffffffff, 0, 0, 0,
          32'hffffffff, 32'hffffffff, 32'hffffffff};                send_pair(v);
  endtask

  initial begin
    sb           = new();
    snd_idle     = 11;
    rcv_idle     = 48;
    n_sent       = 0;
    quiet_cycles = 0;
    rst_ni       = 0;
    in_valid_i   = 0;
    out_stall_i  = 0;
    {eval_x_i, eval_y_i, eval_z_i, src_x_i, src_y_i, src_z_i} = '0;
    {elem_x_i, elem_y_i, elem_z_i} = '0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    send_directed();
    for (int i = 0; i < NumRandom; i++) begin
      if (i == NumRandom / 3) begin
        snd_idle = 48;
        rcv_idle = 11;
      end else if (i == 2 * NumRandom / 3) begin
        snd_idle = 0;
        rcv_idle = 0;
      end
      send_random();
    end
    in_valid_i = 0;

    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("sent %0d pairs, checked %0d results (%0d saturated, %0d zero distance)",
             n_sent, sb.n_checked, sb.n_sat, sb.n_zero);
    $display("mismatches: %0d", sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
